// ===== hdl/sqsm_pkg.sv =====
// Shared types and constants for the shift queue with search and max.
// No dependencies; imported by every module of the block.
package sqsm_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_SEARCH = 3'd2;
  localparam logic [2:0] REQ_MAX    = 3'd3;
  localparam logic [2:0] REQ_SECOND = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] data_value;
  } in_data_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         found_slot;
    logic signed [31:0] result_value;
  } out_data_t;

  typedef struct packed {
    logic               shift;
    logic               load;
    logic signed [31:0] load_val;
  } cell_ctl_t;

  typedef struct packed {
    logic               hit;
    logic [CNT_W-1:0]   slot;
    logic signed [31:0] top;
    logic signed [31:0] second;
    logic               have_second;
  } scan_res_t;

endpackage

// ===== hdl/sqsm_cell.sv =====
// One queue slot: holds a word, loads it, or takes its neighbor's word.
// Depends on sqsm_pkg.
module sqsm_cell import sqsm_pkg::*; (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] nb_val,
  output logic signed [31:0] val_q
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = nb_val;
    end else if (ctl.load) begin
      val_nxt = ctl.load_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;

endmodule

// ===== hdl/sqsm_scan.sv =====
// Accumulator watching the head cell while the ring rotates: first match,
// maximum and largest value strictly below the maximum. Depends on sqsm_pkg.
module sqsm_scan import sqsm_pkg::*; (
  input  logic               clk,
  input  logic               clear,
  input  logic               en,
  input  logic signed [31:0] value,
  input  logic signed [31:0] target,
  input  logic [CNT_W-1:0]   index,
  output scan_res_t          res
);

  logic               hit_r, hit_nxt;
  logic [CNT_W-1:0]   slot_r, slot_nxt;
  logic signed [31:0] top_r, top_nxt;
  logic signed [31:0] sec_r, sec_nxt;
  logic               have_top_r, have_top_nxt;
  logic               have_sec_r, have_sec_nxt;

  always_comb begin
    hit_nxt      = hit_r;
    slot_nxt     = slot_r;
    top_nxt      = top_r;
    sec_nxt      = sec_r;
    have_top_nxt = have_top_r;
    have_sec_nxt = have_sec_r;
    if (clear) begin
      hit_nxt      = 1'b0;
      have_top_nxt = 1'b0;
      have_sec_nxt = 1'b0;
    end else if (en) begin
      if (!hit_r && value == target) begin
        hit_nxt  = 1'b1;
        slot_nxt = index;
      end
      if (!have_top_r) begin
        top_nxt      = value;
        have_top_nxt = 1'b1;
      end else if (value > top_r) begin
        // old maximum drops to second place
        sec_nxt      = top_r;
        have_sec_nxt = 1'b1;
        top_nxt      = value;
      end else if (value < top_r && (!have_sec_r || value > sec_r)) begin
        sec_nxt      = value;
        have_sec_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    slot_r     <= slot_nxt;
    top_r      <= top_nxt;
    sec_r      <= sec_nxt;
    have_top_r <= have_top_nxt;
    have_sec_r <= have_sec_nxt;
  end

  assign res.hit         = hit_r;
  assign res.slot        = slot_r;
  assign res.top         = top_r;
  assign res.second      = sec_r;
  assign res.have_second = have_sec_r;

endmodule

// ===== hdl/shift_queue_search_max.sv =====
// Shift queue with search and max: a ring of QUEUE_DEPTH cells, head in cell 0.
// Insert, delete, error and unused codes: result strobe in the cycle after start,
// busy stays low, so one such request per cycle.
// Search, biggest, second biggest: the ring rotates once past the scan unit
// in S_SCAN, then S_RESULT registers the result strobe; busy is high through
// S_SCAN and S_RESULT. Results cannot be stalled.
// Synchronous active-low reset empties the queue; cell contents are not reset.
module shift_queue_search_max import sqsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_data_t  in_data,
  output logic      out_valid,
  output out_data_t out_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [2:0]         op_r, op_nxt;
  logic signed [31:0] target_r, target_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_data_t          out_r, out_nxt;

  logic               rotate;
  logic               load_en;
  logic               scan_clear;
  logic               scan_en;
  logic               accept;
  scan_res_t          scan_res;

  logic signed [31:0] cell_val [QUEUE_DEPTH];

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      cell_ctl_t ctl;
      assign ctl.shift    = rotate;
      assign ctl.load     = load_en && (fill_r == FILL_W'(gi));
      assign ctl.load_val = in_data.data_value;
      sqsm_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .nb_val (cell_val[(gi + 1) % QUEUE_DEPTH]),
        .val_q  (cell_val[gi])
      );
    end
  endgenerate

  assign scan_en = (state_r == S_SCAN) && ({1'b0, cnt_r} < fill_r);

  sqsm_scan u_scan (
    .clk    (clk),
    .clear  (scan_clear),
    .en     (scan_en),
    .value  (cell_val[0]),
    .target (target_r),
    .index  (cnt_r),
    .res    (scan_res)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    target_nxt    = target_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rotate        = 1'b0;
    load_en       = 1'b0;
    scan_clear    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          op_nxt        = in_data.req_type;
          target_nxt    = in_data.data_value;
          if (in_data.req_type == REQ_INSERT) begin
            if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
              out_nxt.status = ST_FULL;
            end else begin
              load_en  = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
          end else if (in_data.req_type > REQ_SECOND) begin
            out_nxt.status = ST_OK;
          end else if (fill_r == '0) begin
            out_nxt.status = ST_EMPTY;
          end else if (in_data.req_type == REQ_DELETE) begin
            // one rotation step moves every entry down; the old head lands
            // in the top cell, which is beyond the new fill level
            rotate   = 1'b1;
            fill_nxt = fill_r - 1'b1;
          end else begin
            out_valid_nxt = 1'b0;
            scan_clear    = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // full turn of the ring so entries end where they started
        rotate  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUEUE_DEPTH - 1)) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        case (op_r)
          REQ_SEARCH: begin
            if (scan_res.hit) begin
              out_nxt.status       = ST_OK;
              out_nxt.found_slot   = 3'(scan_res.slot);
              out_nxt.result_value = target_r;
            end else begin
              out_nxt.status = ST_NOTFOUND;
            end
          end
          REQ_MAX: begin
            out_nxt.result_value = scan_res.top;
          end
          default: begin
            out_nxt.result_value = scan_res.have_second ? scan_res.second : scan_res.top;
          end
        endcase
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    op_r     <= op_nxt;
    target_r <= target_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
